### design/fxa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared constants, operation codes and the side-band record that travels
// down the pipeline next to the divider.
// ----------------------------------------------------------------------------
package fxa_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;

	// Divider geometry: one quotient bit per step, a fixed number of steps per stage.
	localparam int DIV_BITS      = DATA_W + FRACTION_BITS;
	localparam int STEPS         = 4;
	localparam int DIV_STAGES    = (DIV_BITS + STEPS - 1) / STEPS;
	localparam int PAD_BITS      = DIV_STAGES * STEPS;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} opcode_t;

	// Result of the simple operations plus the flags for the final selection.
	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic              cmp;
		logic              dz;
		logic              is_div;
		logic              is_mul;
		logic              neg;
	} side_t;

endpackage

### design/fxa_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, a few quotient bits per register stage, advancing on
// a shared enable.
// ----------------------------------------------------------------------------
module fxa_div_pipe (
	input  logic                        clk,
	input  logic                        en,
	input  logic [fxa_pkg::PAD_BITS-1:0] dividend,
	input  logic [fxa_pkg::DATA_W-1:0]   divisor,
	output logic [fxa_pkg::PAD_BITS-1:0] quotient
);
	import fxa_pkg::*;

	// Index 0 is the input; index k holds the state after stage k.
	logic [DATA_W-1:0]   rem_s  [0:DIV_STAGES];
	logic [PAD_BITS-1:0] work_s [0:DIV_STAGES];
	logic [DATA_W-1:0]   dvs_s  [0:DIV_STAGES];

	assign rem_s[0]  = '0;
	assign work_s[0] = dividend;
	assign dvs_s[0]  = divisor;

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_stage
			logic [DATA_W-1:0]   rem_n;
			logic [PAD_BITS-1:0] work_n;

			// A group of restoring steps: shift in one dividend bit, subtract if it fits.
			always_comb begin
				logic [DATA_W:0] r;
				rem_n  = rem_s[g];
				work_n = work_s[g];
				for (int k = 0; k < STEPS; k++) begin
					r      = {rem_n, work_n[PAD_BITS-1]};
					work_n = {work_n[PAD_BITS-2:0], 1'b0};
					if (r >= {1'b0, dvs_s[g]}) begin
						r         = r - {1'b0, dvs_s[g]};
						work_n[0] = 1'b1;
					end
					rem_n = r[DATA_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1]  <= rem_n;
					work_s[g+1] <= work_n;
					dvs_s[g+1]  <= dvs_s[g];
				end
			end
		end
	endgenerate

	assign quotient = work_s[DIV_STAGES];

endmodule

### design/fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU core
// Signed 32-bit fixed-point arithmetic, comparison and conversion unit.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries the operation code on s_tuser and both
//   raw operands on s_tdata. Every transaction yields exactly one result
//   transaction on the master side, in order.
//   The pipeline is one input stage that forms operand magnitudes and the
//   simple results, one stage per four quotient bits of the restoring
//   divider, and the output register. The multiplier sits beside the first
//   divider stage.
//   Throughput is one transaction per cycle while the receiver keeps up; all
//   operations share the divider-length pipeline, so results never reorder.
//   The whole pipeline advances whenever the output register is empty or
//   being taken. While the receiver stalls with a result waiting, every
//   stage holds and s_tready is low; nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // operand_a [31:0], operand_b [63:32]
	input  logic [3:0]  s_tuser,  // operation [3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // result_value [31:0], compare_true [32],
	                              // divide_by_zero [33], zero fill [39:34]
);
	import fxa_pkg::*;

	logic                     adv;
	logic signed [DATA_W-1:0] a, b;
	opcode_t                  op;
	side_t                    side_n;
	logic                     lt_ab, lt_ba;

	logic [DATA_W-1:0]   mag_a_s1, mag_b_s1;
	side_t               side_s1;
	logic                valid_s1;

	side_t               side_s   [0:DIV_STAGES-1];
	logic [PROD_W-1:0]   prod_s   [0:DIV_STAGES-1];
	logic [DIV_STAGES-1:0] valid_s;

	logic [PAD_BITS-1:0] quotient;
	logic [DATA_W-1:0]   result_q;
	logic                cmp_q, dz_q;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	assign a  = s_tdata[31:0];
	assign b  = s_tdata[63:32];
	assign op = opcode_t'(s_tuser);

	assign lt_ab = a < b;
	assign lt_ba = b < a;

	// Simple operations and flags, resolved before the first register.
	always_comb begin
		side_n        = '0;
		side_n.neg    = a[DATA_W-1] ^ b[DATA_W-1];
		side_n.is_mul = (op == OP_MUL);
		side_n.is_div = (op == OP_DIV);
		side_n.dz     = (op == OP_DIV) && (b == '0);
		case (op)
			OP_ADD:      side_n.res = a + b;
			OP_SUB:      side_n.res = a - b;
			OP_GT:       side_n.cmp = lt_ba;
			OP_LT:       side_n.cmp = lt_ab;
			OP_GE:       side_n.cmp = !lt_ab;
			OP_LE:       side_n.cmp = !lt_ba;
			OP_EQ:       side_n.cmp = (a == b);
			OP_NE:       side_n.cmp = (a != b);
			OP_MIN:      side_n.res = lt_ab ? a : b;
			OP_MAX:      side_n.res = lt_ba ? a : b;
			OP_INC:      side_n.res = a + 32'sd1;
			OP_DEC:      side_n.res = a - 32'sd1;
			OP_FROM_INT: side_n.res = a <<< FRACTION_BITS;
			OP_TO_INT:   side_n.res = a >>> FRACTION_BITS;
			default:     side_n.res = '0;
		endcase
	end

	// Input stage: magnitudes for the multiplier and divider, and the side-band record.
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_a_s1 <= a[DATA_W-1] ? DATA_W'(-a) : a;
			mag_b_s1 <= b[DATA_W-1] ? DATA_W'(-b) : b;
			side_s1  <= side_n;
		end
	end

	fxa_div_pipe u_div (
		.clk      (clk),
		.en       (adv),
		.dividend (PAD_BITS'(mag_a_s1) << FRACTION_BITS),
		.divisor  (mag_b_s1),
		.quotient (quotient)
	);

	// Side-band and product registers that run beside the divider stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_s1;
			prod_s[0] <= PROD_W'(mag_a_s1) * PROD_W'(mag_b_s1);
			for (int k = 1; k < DIV_STAGES; k++) begin
				side_s[k] <= side_s[k-1];
				prod_s[k] <= prod_s[k-1];
			end
		end
	end

	// Valid bits follow the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s  <= '0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s  <= {valid_s[DIV_STAGES-2:0], valid_s1};
			m_tvalid <= valid_s[DIV_STAGES-1];
		end
	end

	// Output stage: sign correction and selection of the final result.
	always_ff @(posedge clk) begin
		logic [PROD_W-1:0]   p;
		logic [PAD_BITS-1:0] q;
		side_t               sd;
		sd = side_s[DIV_STAGES-1];
		p  = sd.neg ? -prod_s[DIV_STAGES-1] : prod_s[DIV_STAGES-1];
		q  = sd.neg ? -quotient : quotient;
		if (adv) begin
			cmp_q <= sd.cmp;
			dz_q  <= sd.dz;
			if (sd.is_mul)
				result_q <= DATA_W'($signed(p) >>> FRACTION_BITS);
			else if (sd.is_div)
				result_q <= sd.dz ? '0 : q[DATA_W-1:0];
			else
				result_q <= sd.res;
		end
	end

	assign m_tdata = {6'b0, dz_q, cmp_q, result_q};

endmodule
